FILE: rtl/tsc_lru_pkg.sv
// shared types, constants and codes for the template slot cache
package tsc_lru_pkg;

  // table geometry
  localparam int NUM_SLOTS      = 128;
  localparam int RESERVED_SLOTS = 4;
  localparam int IDX_W          = $clog2(NUM_SLOTS);
  localparam bit HAS_ORDINARY   = (RESERVED_SLOTS < NUM_SLOTS);

  // field widths
  localparam int ACT_W    = 2;
  localparam int OWNER_W  = 16;
  localparam int FINGER_W = 4;
  localparam int SLOT_W   = 8;
  localparam int STAMP_W  = 32;
  localparam int STS_W    = 2;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [OWNER_W-1:0]  owner_t;
  typedef logic [FINGER_W-1:0] finger_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [STAMP_W-1:0]  stamp_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ASSIGN = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_MATCH  = 2'd3
  } action_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_MISS  = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_MATCH,
    ST_RESP
  } ctrl_state_t;

  // one stored slot, without the flag bits
  typedef struct packed {
    owner_t  owner;
    finger_t finger;
    stamp_t  stamp;
  } entry_t;

  // one request item
  typedef struct packed {
    action_t action;
    owner_t  owner_id;
    finger_t finger_number;
    slot_t   slot_number;
    stamp_t  now_stamp;
  } req_t;

  // one result item
  typedef struct packed {
    status_t status;
    slot_t   slot_result;
    logic    reused;
    logic    evicted;
    owner_t  match_owner;
    finger_t match_finger;
    logic    time_in;
    logic    reserved_cleared;
  } rsp_t;

  // write-side command into the entry store
  typedef struct packed {
    logic   we;        // write entry and mark it active
    logic   clr;       // mark entry inactive
    logic   flip;      // toggle the in/out bit
    idx_t   idx;
    entry_t data;
  } store_wr_t;

  // read-side request into the entry store
  typedef struct packed {
    logic re;
    idx_t idx;
  } store_rd_t;

endpackage

FILE: rtl/tsc_lru_store.sv
// slot entry memory with per-slot active and toggle flags
module tsc_lru_store
  import tsc_lru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  store_wr_t            wr,
  input  store_rd_t            rd,
  output entry_t               rdata,
  output logic [NUM_SLOTS-1:0] active,
  output logic [NUM_SLOTS-1:0] toggle
);

  entry_t               mem [NUM_SLOTS];
  entry_t               rdata_r;
  logic [NUM_SLOTS-1:0] active_r;
  logic [NUM_SLOTS-1:0] toggle_r;

  // owner, finger and stamp are only read behind an active flag
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd.re) begin
      rdata_r <= mem[rd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      toggle_r <= '0;
    end else begin
      if (wr.we) begin
        active_r[wr.idx] <= 1'b1;
      end else if (wr.clr) begin
        active_r[wr.idx] <= 1'b0;
      end
      if (wr.flip) begin
        toggle_r[wr.idx] <= ~toggle_r[wr.idx];
      end
    end
  end

  assign rdata  = rdata_r;
  assign active = active_r;
  assign toggle = toggle_r;

endmodule

FILE: rtl/tsc_lru_ctrl.sv
// sequencer: slot scan, victim choice, read-modify-write of entries
module tsc_lru_ctrl
  import tsc_lru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  output store_wr_t            wr,
  output store_rd_t            rd,
  input  entry_t               rdata,
  input  logic [NUM_SLOTS-1:0] active,
  input  logic [NUM_SLOTS-1:0] toggle
);

  localparam idx_t LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  ctrl_state_t state_r, state_nxt;

  // captured request
  action_t q_act_r;
  owner_t  q_owner_r;
  finger_t q_finger_r;
  idx_t    q_idx_r;
  stamp_t  q_now_r;

  // scan bookkeeping
  idx_t   rd_idx_r;
  logic   chk_vld_r;
  idx_t   chk_idx_r;
  logic   found_r;
  idx_t   found_idx_r;
  logic   free_r;
  idx_t   free_idx_r;
  logic   old_vld_r;
  idx_t   old_idx_r;
  stamp_t old_stamp_r;

  rsp_t rsp_r, rsp_val;
  logic rsp_load;

  logic  acc;
  logic  slot_ok;
  idx_t  slot_idx;
  slot_t adm_slot;
  logic  chk_act;
  logic  chk_hit;
  logic  chk_ord;

  assign acc      = req_valid && req_ready;
  assign slot_ok  = (req.slot_number != '0) && (req.slot_number <= SLOT_W'(NUM_SLOTS));
  assign slot_idx = IDX_W'(req.slot_number - SLOT_W'(1));

  // administrator slot: finger + 1, falls back to slot 1
  always_comb begin
    adm_slot = SLOT_W'(req.finger_number) + SLOT_W'(1);
    if ((adm_slot > SLOT_W'(RESERVED_SLOTS)) || (adm_slot > SLOT_W'(NUM_SLOTS))) begin
      adm_slot = SLOT_W'(1);
    end
  end

  assign chk_act = active[chk_idx_r];
  assign chk_hit = chk_act && (rdata.owner == q_owner_r) && (rdata.finger == q_finger_r);
  assign chk_ord = (9'(chk_idx_r) >= 9'(RESERVED_SLOTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (req.action)
            ACT_ASSIGN: state_nxt = (req.owner_id == '0) ? ST_RESP : ST_SCAN;
            ACT_LOOKUP: state_nxt = ST_SCAN;
            ACT_DELETE: state_nxt = ST_RESP;
            ACT_MATCH: begin
              state_nxt = (slot_ok && active[slot_idx]) ? ST_MATCH : ST_RESP;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SCAN:   state_nxt = (rd_idx_r == LAST_IDX) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN:  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_RESP;
      ST_MATCH:  state_nxt = ST_RESP;
      ST_RESP:   state_nxt = rsp_ready ? ST_IDLE : ST_RESP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs: store commands and result
  always_comb begin
    req_ready = 1'b0;
    wr        = '0;
    rd        = '0;
    rsp_load  = 1'b0;
    rsp_val   = '0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (acc) begin
          unique case (req.action)
            ACT_ASSIGN: begin
              if (req.owner_id == '0) begin
                wr.we              = 1'b1;
                wr.idx             = IDX_W'(adm_slot - SLOT_W'(1));
                wr.data.owner      = '0;
                wr.data.finger     = req.finger_number;
                wr.data.stamp      = req.now_stamp;
                rsp_load           = 1'b1;
                rsp_val.slot_result = adm_slot;
              end
            end
            ACT_LOOKUP: ;
            ACT_DELETE: begin
              rsp_load = 1'b1;
              if (!slot_ok) begin
                rsp_val.status = STS_RANGE;
              end else begin
                wr.clr                   = 1'b1;
                wr.idx                   = slot_idx;
                rsp_val.slot_result      = req.slot_number;
                rsp_val.reserved_cleared = (req.slot_number <= SLOT_W'(RESERVED_SLOTS));
              end
            end
            ACT_MATCH: begin
              if (!slot_ok) begin
                rsp_load       = 1'b1;
                rsp_val.status = STS_RANGE;
              end else if (!active[slot_idx]) begin
                rsp_load       = 1'b1;
                rsp_val.status = STS_MISS;
              end else begin
                rd.re  = 1'b1;
                rd.idx = slot_idx;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd.re  = 1'b1;
        rd.idx = rd_idx_r;
      end
      ST_DRAIN: ;
      ST_DECIDE: begin
        rsp_load = 1'b1;
        if (q_act_r == ACT_LOOKUP) begin
          if (found_r) begin
            rsp_val.slot_result = SLOT_W'(found_idx_r) + SLOT_W'(1);
          end else begin
            rsp_val.status = STS_MISS;
          end
        end else begin
          wr.data.owner  = q_owner_r;
          wr.data.finger = q_finger_r;
          wr.data.stamp  = q_now_r;
          priority if (found_r) begin
            wr.we               = 1'b1;
            wr.idx              = found_idx_r;
            rsp_val.slot_result = SLOT_W'(found_idx_r) + SLOT_W'(1);
            rsp_val.reused      = 1'b1;
          end else if (!HAS_ORDINARY) begin
            rsp_val.status = STS_MISS;
          end else if (free_r) begin
            wr.we               = 1'b1;
            wr.idx              = free_idx_r;
            rsp_val.slot_result = SLOT_W'(free_idx_r) + SLOT_W'(1);
          end else begin
            wr.we               = 1'b1;
            wr.idx              = old_idx_r;
            rsp_val.slot_result = SLOT_W'(old_idx_r) + SLOT_W'(1);
            rsp_val.evicted     = 1'b1;
          end
        end
      end
      ST_MATCH: begin
        // entry read back last cycle: refresh stamp, flip toggle
        wr.we                = 1'b1;
        wr.flip              = 1'b1;
        wr.idx               = q_idx_r;
        wr.data.owner        = rdata.owner;
        wr.data.finger       = rdata.finger;
        wr.data.stamp        = q_now_r;
        rsp_load             = 1'b1;
        rsp_val.slot_result  = SLOT_W'(q_idx_r) + SLOT_W'(1);
        rsp_val.match_owner  = rdata.owner;
        rsp_val.match_finger = rdata.finger;
        rsp_val.time_in      = ~toggle[q_idx_r];
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= (state_r == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_act_r     <= req.action;
      q_owner_r   <= req.owner_id;
      q_finger_r  <= req.finger_number;
      q_idx_r     <= slot_idx;
      q_now_r     <= req.now_stamp;
      rd_idx_r    <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      old_vld_r   <= 1'b0;
    end else begin
      if (state_r == ST_SCAN) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
      if (chk_vld_r) begin
        if (chk_hit && !found_r) begin
          found_r     <= 1'b1;
          found_idx_r <= chk_idx_r;
        end
        if (chk_ord && !free_r) begin
          if (!chk_act) begin
            free_r     <= 1'b1;
            free_idx_r <= chk_idx_r;
          end else if (!old_vld_r || (rdata.stamp < old_stamp_r)) begin
            old_vld_r   <= 1'b1;
            old_idx_r   <= chk_idx_r;
            old_stamp_r <= rdata.stamp;
          end
        end
      end
    end
    chk_idx_r <= rd_idx_r;
    if (rsp_load) begin
      rsp_r <= rsp_val;
    end
  end

  assign rsp_valid = (state_r == ST_RESP);
  assign rsp       = rsp_r;

endmodule

FILE: rtl/template_slot_cache_lru_core.sv
// top level of the template slot cache with lru replacement
//
// channel | dir | ports                         | payload
// --------+-----+-------------------------------+-----------------------------------------
// in      | in  | in_tvalid/in_tready/in_tdata  | request: owner, finger, slot, stamp
//         |     | in_tuser                      | action code
// out     | out | out_tvalid/out_tready/out_tdata | result: slot, flags, matched entry
//         |     | out_tuser                     | status code
//
// one item is in flight at a time; assign by an ordinary owner and lookup walk
// the slot memory one entry per cycle; a match on an active slot reads its entry
// and then writes it back; delete, administrator assign, a match on an empty slot
// and range errors answer without reading the entry memory
// reset is synchronous, active low, and clears the active and toggle flags of
// every slot at once, so no clearing pass is needed
// the output register holds a finished result while the next transfer is
// already taken in; the sequencer waits only if a second result is ready first
module template_slot_cache_lru_core
  import tsc_lru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] owner_id, [19:16] finger_number, [27:20] slot_number,
  // [59:28] now_stamp, [63:60] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] slot_result, [8] reused, [9] evicted, [25:10] match_owner,
  // [29:26] match_finger, [30] time_in, [31] reserved_cleared
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [STS_W-1:0]      out_tuser
);

  req_t                 req;
  rsp_t                 rsp;
  logic                 rsp_valid;
  logic                 rsp_ready;
  store_wr_t            wr;
  store_rd_t            rd;
  entry_t               rdata;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] toggle;

  logic out_valid_r;
  rsp_t out_rsp_r;

  // unpack the request transfer
  assign req.action        = action_t'(in_tuser);
  assign req.owner_id      = in_tdata[15:0];
  assign req.finger_number = in_tdata[19:16];
  assign req.slot_number   = in_tdata[27:20];
  assign req.now_stamp     = in_tdata[59:28];

  tsc_lru_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd     (rd),
    .rdata  (rdata),
    .active (active),
    .toggle (toggle)
  );

  // the sequencer never reads and writes the same entry in one cycle, so
  // the store needs no forwarding path
  tsc_lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .wr        (wr),
    .rd        (rd),
    .rdata     (rdata),
    .active    (active),
    .toggle    (toggle)
  );

  // output register: loads when empty or when the held result leaves
  assign rsp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rsp_r.status;
  assign out_tdata  = {out_rsp_r.reserved_cleared,
                       out_rsp_r.time_in,
                       out_rsp_r.match_finger,
                       out_rsp_r.match_owner,
                       out_rsp_r.evicted,
                       out_rsp_r.reused,
                       out_rsp_r.slot_result};

endmodule

FILE: sim/template_slot_cache_lru_core_chk.sv
// checker for the template slot cache: tracks the slot table, predicts each result, compares
`timescale 1ns / 100ps
module template_slot_cache_lru_core_chk
  import tsc_lru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [ACT_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [STS_W-1:0]      out_tuser,
  output int                    fail_count,
  output int                    outstanding
);

  // shadow copy of the slot table, index 0 is slot 1
  logic    slot_active [NUM_SLOTS];
  owner_t  slot_owner  [NUM_SLOTS];
  finger_t slot_finger [NUM_SLOTS];
  stamp_t  slot_stamp  [NUM_SLOTS];
  logic    slot_in     [NUM_SLOTS];

  rsp_t expected_results [$];
  int   errs;

  initial begin
    errs = 0;
  end

  function automatic int find_slot(owner_t own, finger_t fin);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_active[i] && slot_owner[i] == own && slot_finger[i] == fin) return i + 1;
    return 0;
  endfunction

  function automatic void store_entry(int s, owner_t own, finger_t fin, stamp_t now);
    slot_active[s-1] = 1'b1;
    slot_owner[s-1]  = own;
    slot_finger[s-1] = fin;
    slot_stamp[s-1]  = now;
  endfunction

  function automatic rsp_t predict_slot_result(action_t act, owner_t own, finger_t fin,
                                               slot_t sl, stamp_t now);
    rsp_t   r;
    int     s;
    int     oldest;
    stamp_t oldest_t;
    int     free_slot;
    r = '0;
    r.status = STS_DONE;
    case (act)
      ACT_ASSIGN: begin
        if (own == '0) begin
          // administrator goes to its reserved slot, clamped to slot 1
          s = int'(fin) + 1;
          if (s > RESERVED_SLOTS || s > NUM_SLOTS) s = 1;
          store_entry(s, '0, fin, now);
          r.slot_result = slot_t'(s);
        end else begin
          s = find_slot(own, fin);
          if (s != 0) begin
            slot_stamp[s-1] = now;
            r.slot_result   = slot_t'(s);
            r.reused        = 1'b1;
          end else if (!HAS_ORDINARY) begin
            r.status = STS_MISS;
          end else begin
            oldest    = RESERVED_SLOTS + 1;
            oldest_t  = '1;
            free_slot = 0;
            for (int i = RESERVED_SLOTS; i < NUM_SLOTS; i++) begin
              if (!slot_active[i]) begin
                free_slot = i + 1;
                break;
              end
              if (slot_stamp[i] < oldest_t) begin
                oldest_t = slot_stamp[i];
                oldest   = i + 1;
              end
            end
            if (free_slot != 0) begin
              s = free_slot;
            end else begin
              s = oldest;
              r.evicted = 1'b1;
            end
            store_entry(s, own, fin, now);
            r.slot_result = slot_t'(s);
          end
        end
      end
      ACT_LOOKUP: begin
        s = find_slot(own, fin);
        if (s != 0) r.slot_result = slot_t'(s);
        else r.status = STS_MISS;
      end
      default: begin
        if (sl == '0 || sl > NUM_SLOTS) begin
          r.status = STS_RANGE;
        end else if (act == ACT_DELETE) begin
          slot_active[sl-1]  = 1'b0;
          r.slot_result      = sl;
          r.reserved_cleared = (sl <= RESERVED_SLOTS);
        end else if (!slot_active[sl-1]) begin
          r.status = STS_MISS;
        end else begin
          slot_stamp[sl-1] = now;
          slot_in[sl-1]    = ~slot_in[sl-1];
          r.slot_result    = sl;
          r.match_owner    = slot_owner[sl-1];
          r.match_finger   = slot_finger[sl-1];
          r.time_in        = slot_in[sl-1];
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_active[i] = 1'b0;
        slot_owner[i]  = '0;
        slot_finger[i] = '0;
        slot_stamp[i]  = '0;
        slot_in[i]     = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request waiting");
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("slot_result", want.slot_result, out_tdata[7:0]);
          check_field("reused", want.reused, out_tdata[8]);
          check_field("evicted", want.evicted, out_tdata[9]);
          check_field("match_owner", want.match_owner, out_tdata[25:10]);
          check_field("match_finger", want.match_finger, out_tdata[29:26]);
          check_field("time_in", want.time_in, out_tdata[30]);
          check_field("reserved_cleared", want.reserved_cleared, out_tdata[31]);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_slot_result(action_t'(in_tuser), in_tdata[15:0],
                                                       in_tdata[19:16], in_tdata[27:20],
                                                       in_tdata[59:28]));
    end
    fail_count  <= errs;
    outstanding <= expected_results.size();
  end

endmodule

FILE: sim/template_slot_cache_lru_core_tb.sv
// testbench top for the template slot cache: stimulus, handshake pressure and verdict
`timescale 1ns / 100ps
module template_slot_cache_lru_core_tb;
  import tsc_lru_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [ACT_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STS_W-1:0]      out_tuser;

  int     fail_count;
  int     outstanding;
  int     tx_idle_pct   = 0;
  int     rx_idle_pct   = 0;
  int     hold_requests = 0;
  stamp_t stamp_now     = 32'd1000;

  template_slot_cache_lru_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  template_slot_cache_lru_core_chk i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // safety net: the slowest correct run is far below this
  initial begin
    #40_000_000;
    $display("template_slot_cache_lru_core regression: fail");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin : result_side
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        out_tready <= 1'b0;
        // long enough for the output register and the sequencer to fill and block input
        repeat (3000) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one request and hold it until the transfer, then maybe idle a while
  task automatic send_item(action_t act, owner_t own, finger_t fin, slot_t sl, stamp_t now);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0, now, sl, fin, own};
    do @(posedge clk); while (!in_tready);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender stops until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_item();
    int      pick;
    action_t act;
    owner_t  own;
    finger_t fin;
    slot_t   sl;
    stamp_t  now;
    pick = $urandom_range(99);
    // small owner pool so entries get reused, looked up and matched; rare full-range owners
    if ($urandom_range(9) == 0) own = owner_t'($urandom());
    else own = owner_t'($urandom_range(64, 1));
    if ($urandom_range(3) == 0) fin = finger_t'($urandom_range(15));
    else fin = finger_t'($urandom_range(7));
    // slot numbers mostly valid, with the edges and out-of-range values mixed in
    case ($urandom_range(19))
      0:       sl = '0;
      1:       sl = slot_t'($urandom_range(255, NUM_SLOTS + 1));
      2:       sl = slot_t'(NUM_SLOTS);
      3:       sl = slot_t'($urandom_range(RESERVED_SLOTS, 1));
      default: sl = slot_t'($urandom_range(NUM_SLOTS, 1));
    endcase
    // time mostly runs forward; repeats give stamp ties, rare jumps cover the full range
    case ($urandom_range(19))
      0:       now = stamp_t'($urandom());
      1:       now = stamp_now;
      default: begin
        stamp_now = stamp_now + stamp_t'($urandom_range(50, 1));
        now       = stamp_now;
      end
    endcase
    if (pick < 5) begin
      act = ACT_ASSIGN;
      own = '0;
    end else if (pick < 50) begin
      act = ACT_ASSIGN;
    end else if (pick < 68) begin
      act = ACT_LOOKUP;
    end else if (pick < 76) begin
      act = ACT_DELETE;
    end else begin
      act = ACT_MATCH;
    end
    send_item(act, own, fin, sl, now);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 6;
    rx_idle_pct <= 85;

    // empty table: miss, empty slot, range errors at both ends
    send_item(ACT_LOOKUP, 16'd1, 4'd0, 8'd0, 32'd10);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd5, 32'd11);
    send_item(ACT_DELETE, 16'd0, 4'd0, 8'd0, 32'd12);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd129, 32'd13);
    send_item(ACT_DELETE, 16'd0, 4'd0, 8'd255, 32'd14);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd0, 32'd15);
    // administrator: reserved slots, then fingers past the reserved range clamp to slot 1
    send_item(ACT_ASSIGN, 16'd0, 4'd0, 8'd0, 32'd0);
    send_item(ACT_ASSIGN, 16'd0, 4'd3, 8'd0, 32'd20);
    send_item(ACT_ASSIGN, 16'd0, 4'd4, 8'd0, 32'd21);
    send_item(ACT_ASSIGN, 16'd0, 4'd15, 8'd0, 32'hFFFF_FFFF);
    // ordinary owner at the field extremes, then reuse of the same entry
    send_item(ACT_ASSIGN, 16'hFFFF, 4'd15, 8'd0, 32'hFFFF_FFFF);
    send_item(ACT_ASSIGN, 16'hFFFF, 4'd15, 8'd0, 32'd7);
    send_item(ACT_LOOKUP, 16'hFFFF, 4'd15, 8'd0, 32'd30);
    send_item(ACT_LOOKUP, 16'd0, 4'd15, 8'd0, 32'd31);
    // toggle goes in, then out; match on an administrator slot
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd5, 32'd40);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd5, 32'd41);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd1, 32'd42);
    send_item(ACT_ASSIGN, 16'd1, 4'd0, 8'd0, 32'd50);
    // delete: reserved slot, last slot while inactive, ordinary slot
    send_item(ACT_DELETE, 16'd0, 4'd0, 8'd4, 32'd60);
    send_item(ACT_DELETE, 16'd0, 4'd0, 8'd128, 32'd61);
    send_item(ACT_DELETE, 16'd0, 4'd0, 8'd5, 32'd62);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd5, 32'd63);
    // freed hole below slot 6 is taken first
    send_item(ACT_ASSIGN, 16'hFFFF, 4'd15, 8'd0, 32'd64);
    send_item(ACT_MATCH,  16'd0, 4'd0, 8'd4, 32'd65);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct <= 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct <= 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < 480; n++) begin
        // result side stops for a long stretch while requests keep coming
        if (phase == 2 && n == 100) hold_requests <= hold_requests + 1;
        send_random_item();
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("template_slot_cache_lru_core regression: pass");
    end else begin
      $display("template_slot_cache_lru_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tsc_lru_pkg.sv
rtl/tsc_lru_store.sv
rtl/tsc_lru_ctrl.sv
rtl/template_slot_cache_lru_core.sv
sim/template_slot_cache_lru_core_chk.sv
sim/template_slot_cache_lru_core_tb.sv
